[hdl/hrbd_pkg.sv]
`default_nettype none

package hrbd_pkg;

    // item action codes
    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_SAMPLE = 2'd1;
    localparam logic [1:0] ACT_PRESS  = 2'd2;

    // configuration register indexes
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 17;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TRIGGER    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RELEASE    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REFRACTORY = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DEBOUNCE   = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TPM        = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_RATE_CAP   = 3'd5;

    // fixed field widths
    localparam int LEVEL_WIDTH    = 12;
    localparam int REFR_WIDTH     = 8;
    localparam int AGE_WIDTH      = 16;
    localparam int TPM_WIDTH      = 17;
    localparam int RATE_WIDTH     = 10;
    localparam int INTERVAL_WIDTH = 17;
    localparam int CMP_WIDTH      = 16;

    // register reset values
    localparam logic [LEVEL_WIDTH-1:0] TRIGGER_RST    = 12'd1923;
    localparam logic [LEVEL_WIDTH-1:0] RELEASE_RST    = 12'd1675;
    localparam logic [REFR_WIDTH-1:0]  REFRACTORY_RST = 8'd2;
    localparam logic [AGE_WIDTH-1:0]   DEBOUNCE_RST   = 16'd300;
    localparam logic [TPM_WIDTH-1:0]   TPM_RST        = 17'd60000;
    localparam logic [RATE_WIDTH-1:0]  RATE_CAP_RST   = 10'd999;

    // parameter defaults
    localparam int COUNT_WIDTH_DEF  = 17;
    localparam int SAMPLE_WIDTH_DEF = 12;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

[hdl/hrbd_div.sv]
`default_nettype none

// Restoring divider, one quotient bit per cycle, result capped.
module hrbd_div #(
    parameter int COUNT_WIDTH = hrbd_pkg::COUNT_WIDTH_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_start,
    input  wire logic [hrbd_pkg::TPM_WIDTH-1:0]  i_dividend,
    input  wire logic [COUNT_WIDTH-1:0]          i_divisor,
    input  wire logic [hrbd_pkg::RATE_WIDTH-1:0] i_cap,
    output hrbd_pkg::t_div_stat                  o_stat,
    output logic      [hrbd_pkg::RATE_WIDTH-1:0] o_result
);

    localparam int STEPS = hrbd_pkg::TPM_WIDTH;
    localparam int CNT_W = $clog2(STEPS);

    logic                   r_busy;
    logic                   r_done;
    logic [CNT_W-1:0]       r_cnt;
    logic [COUNT_WIDTH-1:0] r_rem;
    logic [STEPS-1:0]       r_quo;
    logic [COUNT_WIDTH-1:0] r_dvs;
    logic                   r_zero;

    logic [COUNT_WIDTH:0]   rem_sh;
    logic [COUNT_WIDTH+1:0] diff;
    logic                   fits;

    assign rem_sh = {r_rem, r_quo[STEPS-1]};
    assign diff   = {1'b0, rem_sh} - (COUNT_WIDTH+2)'(r_dvs);
    assign fits   = ~diff[COUNT_WIDTH+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quo  <= i_dividend;
            r_dvs  <= i_divisor;
            r_zero <= (i_divisor == '0);
        end else if (r_busy) begin
            r_rem <= fits ? diff[COUNT_WIDTH-1:0] : rem_sh[COUNT_WIDTH-1:0];
            r_quo <= {r_quo[STEPS-2:0], fits};
        end
    end

    always_comb begin
        if (r_zero) begin
            o_result = '0;
        end else if (r_quo > STEPS'(i_cap)) begin
            o_result = i_cap;
        end else begin
            o_result = r_quo[hrbd_pkg::RATE_WIDTH-1:0];
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

[hdl/heart_rate_beat_detector.sv]
`default_nettype none

// Beat detector and rate meter. Each input item is a millisecond tick, a
// converter sample or a start-button press, and each item gives exactly one
// result item. A sample at or above trigger_level sets the beat level once
// the interval count exceeds refractory_ticks (or while the first beat after
// start is awaited); a sample below release_level clears it. While running,
// a rising beat edge restarts the interval count: the first edge after start
// only syncs, each later edge captures the interval and flags rate_valid.
// beats_per_minute is ticks_per_minute / interval, capped at rate_cap, and 0
// for a zero interval. Presses toggle running when more than debounce_ticks
// ticks have passed since the last accepted press. A single 17-step restoring
// divider (one quotient bit per cycle) recomputes the rate for every item: an
// item is accepted, its quotient collected and its result handed on to the
// output register before the next item is taken. That register lets the next
// item be accepted while a result waits. The user must write configuration
// (i_cfg_we/i_cfg_index/i_cfg_data) only while idle, unenforced by the block.
module heart_rate_beat_detector #(
    parameter int COUNT_WIDTH  = hrbd_pkg::COUNT_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = hrbd_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [hrbd_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  wire logic [hrbd_pkg::CFG_DATA_WIDTH-1:0] i_cfg_data,
    // input items
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic [1:0]                          i_action,
    input  wire logic [SAMPLE_WIDTH-1:0]             i_sample,
    // result items
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic                                     o_beat_active,
    output logic                                     o_running,
    output logic                                     o_awaiting_first,
    output logic                                     o_rate_valid,
    output logic [hrbd_pkg::INTERVAL_WIDTH-1:0]      o_interval_ticks,
    output logic [hrbd_pkg::RATE_WIDTH-1:0]          o_beats_per_minute
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_WAIT
    } t_state;

    localparam int CMPW = hrbd_pkg::CMP_WIDTH;

    t_state r_state;

    // configuration registers
    logic [hrbd_pkg::LEVEL_WIDTH-1:0] r_trig;
    logic [hrbd_pkg::LEVEL_WIDTH-1:0] r_rel;
    logic [hrbd_pkg::REFR_WIDTH-1:0]  r_refr;
    logic [hrbd_pkg::AGE_WIDTH-1:0]   r_deb;
    logic [hrbd_pkg::TPM_WIDTH-1:0]   r_tpm;
    logic [hrbd_pkg::RATE_WIDTH-1:0]  r_cap;

    // detector state
    logic                           r_beat, n_beat;
    logic                           r_prev, n_prev;
    logic                           r_first, n_first;
    logic                           r_run, n_run;
    logic [COUNT_WIDTH-1:0]         r_cnt, n_cnt;
    logic [hrbd_pkg::AGE_WIDTH-1:0] r_age, n_age;
    logic [COUNT_WIDTH-1:0]         r_capt, n_capt;
    logic                           n_captured;

    // result held while the rate is computed
    logic                            r_pend_capt;
    logic [hrbd_pkg::RATE_WIDTH-1:0] r_pend_bpm;

    logic                            accept;
    logic                            slot_free;
    hrbd_pkg::t_div_stat             div_stat;
    logic [hrbd_pkg::RATE_WIDTH-1:0] div_result;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign slot_free  = !o_out_valid || i_out_ready;

    // next detector state for the item being accepted
    always_comb begin
        n_beat     = r_beat;
        n_run      = r_run;
        n_cnt      = r_cnt;
        n_age      = r_age;
        n_capt     = r_capt;
        n_first    = r_first;
        n_prev     = r_prev;
        n_captured = 1'b0;

        case (i_action)
            hrbd_pkg::ACT_TICK: begin
                if (r_cnt != '1) begin
                    n_cnt = r_cnt + 1'b1;
                end
                if (r_age != '1) begin
                    n_age = r_age + 1'b1;
                end
            end
            hrbd_pkg::ACT_SAMPLE: begin
                if ((CMPW'(i_sample) >= CMPW'(r_trig)) &&
                    ((r_cnt > COUNT_WIDTH'(r_refr)) || r_first)) begin
                    n_beat = 1'b1;
                end else if (CMPW'(i_sample) < CMPW'(r_rel)) begin
                    n_beat = 1'b0;
                end
            end
            hrbd_pkg::ACT_PRESS: begin
                if (r_age > r_deb) begin
                    n_run = !r_run;
                    n_age = '0;
                end
            end
            default: begin
            end
        endcase

        // edge logic after every item
        if (n_run) begin
            if (n_beat && !r_prev) begin
                if (r_first) begin
                    n_first = 1'b0;
                end else begin
                    n_capt     = n_cnt;
                    n_captured = 1'b1;
                end
                n_cnt = '0;
            end
            n_prev = n_beat;
        end else begin
            n_first = 1'b1;
            n_prev  = 1'b0;
        end
    end

    hrbd_div #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (accept),
        .i_dividend (r_tpm),
        .i_divisor  (n_capt),
        .i_cap      (r_cap),
        .o_stat     (div_stat),
        .o_result   (div_result)
    );

    // sequencer, detector state, configuration and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            o_out_valid <= 1'b0;
            r_trig      <= hrbd_pkg::TRIGGER_RST;
            r_rel       <= hrbd_pkg::RELEASE_RST;
            r_refr      <= hrbd_pkg::REFRACTORY_RST;
            r_deb       <= hrbd_pkg::DEBOUNCE_RST;
            r_tpm       <= hrbd_pkg::TPM_RST;
            r_cap       <= hrbd_pkg::RATE_CAP_RST;
            r_beat      <= 1'b0;
            r_prev      <= 1'b0;
            r_first     <= 1'b1;
            r_run       <= 1'b0;
            r_cnt       <= '0;
            r_age       <= '0;
            r_capt      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    hrbd_pkg::REG_TRIGGER:    r_trig <= i_cfg_data[hrbd_pkg::LEVEL_WIDTH-1:0];
                    hrbd_pkg::REG_RELEASE:    r_rel  <= i_cfg_data[hrbd_pkg::LEVEL_WIDTH-1:0];
                    hrbd_pkg::REG_REFRACTORY: r_refr <= i_cfg_data[hrbd_pkg::REFR_WIDTH-1:0];
                    hrbd_pkg::REG_DEBOUNCE:   r_deb  <= i_cfg_data[hrbd_pkg::AGE_WIDTH-1:0];
                    hrbd_pkg::REG_TPM:        r_tpm  <= i_cfg_data[hrbd_pkg::TPM_WIDTH-1:0];
                    hrbd_pkg::REG_RATE_CAP:   r_cap  <= i_cfg_data[hrbd_pkg::RATE_WIDTH-1:0];
                    default: begin
                    end
                endcase
            end

            // in S_WAIT the handoff below decides the valid on its own
            if (o_out_valid && i_out_ready && (r_state != S_WAIT)) begin
                o_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_beat  <= n_beat;
                        r_prev  <= n_prev;
                        r_first <= n_first;
                        r_run   <= n_run;
                        r_cnt   <= n_cnt;
                        r_age   <= n_age;
                        r_capt  <= n_capt;
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_stat.done) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    if (slot_free) begin
                        o_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_pend_capt <= n_captured;
        end
        if (r_state == S_DIV && div_stat.done) begin
            r_pend_bpm <= div_result;
        end
        if (r_state == S_WAIT && slot_free) begin
            o_beat_active      <= r_beat;
            o_running          <= r_run;
            o_awaiting_first   <= r_first;
            o_rate_valid       <= r_pend_capt;
            o_interval_ticks   <= hrbd_pkg::INTERVAL_WIDTH'(r_capt);
            o_beats_per_minute <= r_pend_bpm;
        end
    end

`ifndef SYNTHESIS
    a_div_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> div_stat.busy)
        else $error("divider did not start after item");

    a_busy_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> !o_in_ready)
        else $error("item accepted while divider busy");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV))
        else $error("divider result outside divide state");

    a_capture_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_rate_valid) |-> (o_running && !o_awaiting_first))
        else $error("capture flagged while stopped or unsynced");

    a_stop_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_running) |-> o_awaiting_first)
        else $error("stopped without awaiting first beat");
`endif

endmodule

`default_nettype wire

[tb/sv/beat_rate_checker.sv]
module beat_rate_checker #(
    parameter int COUNT_WIDTH  = hrbd_pkg::COUNT_WIDTH_DEF,
    parameter int SAMPLE_WIDTH = hrbd_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [hrbd_pkg::CFG_INDEX_WIDTH-1:0] i_cfg_index,
    input  logic [hrbd_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic [1:0]                           i_action,
    input  logic [SAMPLE_WIDTH-1:0]              i_sample,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic                                 i_beat_active,
    input  logic                                 i_running,
    input  logic                                 i_awaiting_first,
    input  logic                                 i_rate_valid,
    input  logic [hrbd_pkg::INTERVAL_WIDTH-1:0]  i_interval_ticks,
    input  logic [hrbd_pkg::RATE_WIDTH-1:0]      i_beats_per_minute,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import hrbd_pkg::*;

    typedef struct packed {
        logic                      beat_active;
        logic                      running;
        logic                      awaiting_first;
        logic                      rate_valid;
        logic [INTERVAL_WIDTH-1:0] interval_ticks;
        logic [RATE_WIDTH-1:0]     beats_per_minute;
    } beat_reading_t;

    // register copies
    logic [LEVEL_WIDTH-1:0] trigger_lvl;
    logic [LEVEL_WIDTH-1:0] release_lvl;
    logic [REFR_WIDTH-1:0]  refractory;
    logic [AGE_WIDTH-1:0]   debounce;
    logic [TPM_WIDTH-1:0]   tick_rate;
    logic [RATE_WIDTH-1:0]  rate_limit;

    // detector state
    logic                   beat_lvl;
    logic                   last_lvl;
    logic                   first_wait;
    logic                   run_on;
    logic [COUNT_WIDTH-1:0] beat_count;
    logic [AGE_WIDTH-1:0]   press_age;
    logic [COUNT_WIDTH-1:0] last_interval;

    beat_reading_t expected_readings[$];
    int            fail_total = 0;

    function automatic beat_reading_t predict_reading(logic [1:0] act,
                                                      logic [SAMPLE_WIDTH-1:0] smp);
        beat_reading_t r;
        logic          captured;
        logic [63:0]   quot;
        captured = 1'b0;
        case (act)
            ACT_TICK: begin
                if (beat_count != '1) beat_count = beat_count + 1'b1;
                if (press_age != '1) press_age = press_age + 1'b1;
            end
            ACT_SAMPLE: begin
                if (smp >= trigger_lvl && (beat_count > refractory || first_wait))
                    beat_lvl = 1'b1;
                else if (smp < release_lvl)
                    beat_lvl = 1'b0;
            end
            ACT_PRESS: begin
                if (press_age > debounce) begin
                    run_on    = !run_on;
                    press_age = '0;
                end
            end
            default: ;
        endcase

        // edge logic runs after every item
        if (run_on) begin
            if (beat_lvl && !last_lvl) begin
                if (first_wait) begin
                    first_wait = 1'b0;
                end else begin
                    last_interval = beat_count;
                    captured      = 1'b1;
                end
                beat_count = '0;
            end
            last_lvl = beat_lvl;
        end else begin
            first_wait = 1'b1;
            last_lvl   = 1'b0;
        end

        if (last_interval == '0) begin
            quot = '0;
        end else begin
            quot = 64'(tick_rate);
            quot = quot / 64'(last_interval);
            if (quot > 64'(rate_limit)) quot = 64'(rate_limit);
        end

        r.beat_active      = beat_lvl;
        r.running          = run_on;
        r.awaiting_first   = first_wait;
        r.rate_valid       = captured;
        r.interval_ticks   = INTERVAL_WIDTH'(last_interval);
        r.beats_per_minute = quot[RATE_WIDTH-1:0];
        return r;
    endfunction

    function automatic void check_field(string fname, logic [31:0] want, logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", fname, want, got);
            fail_total++;
        end
    endfunction

    always @(posedge i_clk) begin : watch_channels
        beat_reading_t want;
        if (!i_rst_n) begin
            trigger_lvl   = TRIGGER_RST;
            release_lvl   = RELEASE_RST;
            refractory    = REFRACTORY_RST;
            debounce      = DEBOUNCE_RST;
            tick_rate     = TPM_RST;
            rate_limit    = RATE_CAP_RST;
            beat_lvl      = 1'b0;
            last_lvl      = 1'b0;
            first_wait    = 1'b1;
            run_on        = 1'b0;
            beat_count    = '0;
            press_age     = '0;
            last_interval = '0;
            expected_readings.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_TRIGGER:    trigger_lvl = i_cfg_data[LEVEL_WIDTH-1:0];
                    REG_RELEASE:    release_lvl = i_cfg_data[LEVEL_WIDTH-1:0];
                    REG_REFRACTORY: refractory  = i_cfg_data[REFR_WIDTH-1:0];
                    REG_DEBOUNCE:   debounce    = i_cfg_data[AGE_WIDTH-1:0];
                    REG_TPM:        tick_rate   = i_cfg_data[TPM_WIDTH-1:0];
                    REG_RATE_CAP:   rate_limit  = i_cfg_data[RATE_WIDTH-1:0];
                    default: ;
                endcase
            end
            // a result can never belong to the item taken at the same edge
            if (i_out_valid && i_out_ready) begin
                if (expected_readings.size() == 0) begin
                    $error("result item arrived with no item outstanding");
                    fail_total++;
                end else begin
                    want = expected_readings.pop_front();
                    check_field("beat_active", 32'(want.beat_active), 32'(i_beat_active));
                    check_field("running", 32'(want.running), 32'(i_running));
                    check_field("awaiting_first", 32'(want.awaiting_first),
                                32'(i_awaiting_first));
                    check_field("rate_valid", 32'(want.rate_valid), 32'(i_rate_valid));
                    check_field("interval_ticks", 32'(want.interval_ticks),
                                32'(i_interval_ticks));
                    check_field("beats_per_minute", 32'(want.beats_per_minute),
                                32'(i_beats_per_minute));
                end
            end
            if (i_in_valid && i_in_ready)
                expected_readings.push_back(predict_reading(i_action, i_sample));
        end
        o_fail_count <= fail_total;
        o_pending    <= expected_readings.size();
    end

endmodule

[tb/sv/tb_heart_rate_beat_detector.sv]
module tb_heart_rate_beat_detector;
    import hrbd_pkg::*;

    // action code the block must treat as a no-op
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int IDLE_PCT       = 12;    // per-cycle idle chance, each side
    localparam int STALL_CYCLES   = 300;   // long receiver hold-off
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake at all
    localparam int DRAIN_TAIL     = 40;    // idle tail after the last result

    typedef enum int {BEAT_WAIT, BEAT_PEAK, BEAT_FALL} beat_stage_t;

    logic                       clk         = 1'b0;
    logic                       rst_n       = 1'b0;
    logic                       cfg_we      = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index   = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data    = '0;
    logic                       in_valid    = 1'b0;
    logic                       in_ready;
    logic [1:0]                 action      = ACT_TICK;
    logic [LEVEL_WIDTH-1:0]     sample      = '0;
    logic                       out_valid;
    logic                       out_ready   = 1'b0;
    logic                       beat_active;
    logic                       running;
    logic                       awaiting_first;
    logic                       rate_valid;
    logic [INTERVAL_WIDTH-1:0]  interval_ticks;
    logic [RATE_WIDTH-1:0]      beats_per_minute;

    int fail_count;
    int pending;

    // stimulus-side knobs
    bit gaps_on   = 1'b1;  // random idling on both channels
    int stall_req = 0;     // bumped to ask the receiver for one long hold-off
    int cur_trig  = int'(TRIGGER_RST);
    int cur_rel   = int'(RELEASE_RST);

    heart_rate_beat_detector dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .o_in_ready         (in_ready),
        .i_action           (action),
        .i_sample           (sample),
        .o_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .o_beat_active      (beat_active),
        .o_running          (running),
        .o_awaiting_first   (awaiting_first),
        .o_rate_valid       (rate_valid),
        .o_interval_ticks   (interval_ticks),
        .o_beats_per_minute (beats_per_minute)
    );

    beat_rate_checker checker_i (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_cfg_we           (cfg_we),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data),
        .i_in_valid         (in_valid),
        .i_in_ready         (in_ready),
        .i_action           (action),
        .i_sample           (sample),
        .i_out_valid        (out_valid),
        .i_out_ready        (out_ready),
        .i_beat_active      (beat_active),
        .i_running          (running),
        .i_awaiting_first   (awaiting_first),
        .i_rate_valid       (rate_valid),
        .i_interval_ticks   (interval_ticks),
        .i_beats_per_minute (beats_per_minute),
        .o_fail_count       (fail_count),
        .o_pending          (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Offer one item. Random idle cycles go in front of it; valid then holds
    // with a steady payload until the item is taken.
    task automatic send_item(logic [1:0] a, logic [LEVEL_WIDTH-1:0] s);
        while (gaps_on && $urandom_range(99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= a;
        sample   <= s;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Stop offering and wait until every outstanding result has been taken.
    // The pending count is registered, so always wait for an edge before looking.
    task automatic drain_results();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] idx, int val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_DATA_WIDTH-1:0];
        @(posedge clk);
    endtask

    // Registers only change with the block idle: drain first, then write all six.
    task automatic set_config(int trig, int rel, int refr, int deb, int tpm, int cap);
        drain_results();
        write_reg(REG_TRIGGER, trig);
        write_reg(REG_RELEASE, rel);
        write_reg(REG_REFRACTORY, refr);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_TPM, tpm);
        write_reg(REG_RATE_CAP, cap);
        cfg_we   <= 1'b0;
        cur_trig = trig;
        cur_rel  = rel;
    endtask

    // Pulse-like stream: a run of ticks, a peak sample at or above trigger,
    // sometimes a sample inside the hysteresis band, then a sample below
    // release. Presses and random items are mixed in as noise (per mille).
    task automatic play_rhythm(int n_items, int min_gap, int max_gap, int press_pm);
        int                     gap;
        int                     roll;
        beat_stage_t            stage;
        logic [1:0]             a;
        logic [LEVEL_WIDTH-1:0] s;
        int                     hi_smp;
        int                     mid_smp;
        int                     lo_smp;
        gap   = $urandom_range(max_gap, min_gap);
        stage = BEAT_WAIT;
        repeat (n_items) begin
            roll    = $urandom_range(999);
            s       = LEVEL_WIDTH'($urandom_range(4095));
            hi_smp  = $urandom_range(4095, cur_trig);
            mid_smp = (cur_trig > cur_rel) ? $urandom_range(cur_trig - 1, cur_rel)
                                           : $urandom_range(4095);
            lo_smp  = (cur_rel > 0) ? $urandom_range(cur_rel - 1, 0) : $urandom_range(4095);
            if (roll < press_pm) begin
                a = ACT_PRESS;
            end else if (roll < press_pm + 60) begin
                a = 2'($urandom_range(3));
            end else if (stage == BEAT_WAIT && gap > 0) begin
                a = ACT_TICK;
                gap--;
            end else begin
                a = ACT_SAMPLE;
                case (stage)
                    BEAT_WAIT: begin
                        s     = LEVEL_WIDTH'(hi_smp);
                        stage = BEAT_PEAK;
                    end
                    BEAT_PEAK: begin
                        s     = LEVEL_WIDTH'($urandom_range(1) ? mid_smp : hi_smp);
                        stage = BEAT_FALL;
                    end
                    default: begin
                        s     = LEVEL_WIDTH'(lo_smp);
                        stage = BEAT_WAIT;
                        gap   = $urandom_range(max_gap, min_gap);
                    end
                endcase
            end
            send_item(a, s);
        end
    endtask

    // Receiver: random ready, or one long hold-off per request while the
    // sender keeps offering, so the block backs up and stalls its input.
    initial begin
        int served;
        served = 0;
        forever begin
            @(posedge clk);
            if (stall_req != served) begin
                served = stall_req;
                out_ready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end else if (gaps_on) begin
                out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    // Watchdog: ends the run if no handshake happens on either channel for
    // far longer than the slowest legal run would ever need.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int trig;
        int rel;
        int refr;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: no debounce and no refractory window so every rule shows
        // up within a few items.
        set_config(int'(TRIGGER_RST), int'(RELEASE_RST), 0, 0,
                   int'(TPM_RST), int'(RATE_CAP_RST));
        send_item(ACT_SAMPLE, 12'hFFF);     // stopped, first beat awaited: level sets
        send_item(ACT_SAMPLE, 12'h000);     // below release: clears
        send_item(ACT_UNUSED, 12'hAAA);     // unused code: nothing moves
        send_item(ACT_PRESS, 12'h555);      // press age not past debounce: ignored
        send_item(ACT_TICK, 12'h555);
        send_item(ACT_PRESS, 12'hAAA);      // accepted: starts running
        send_item(ACT_SAMPLE, TRIGGER_RST); // exactly at trigger: first edge only syncs
        send_item(ACT_SAMPLE, RELEASE_RST); // exactly at release: level holds
        send_item(ACT_SAMPLE, LEVEL_WIDTH'(RELEASE_RST - 1));
        send_item(ACT_TICK, 12'h000);
        send_item(ACT_TICK, 12'hFFF);
        send_item(ACT_TICK, 12'h000);
        send_item(ACT_SAMPLE, LEVEL_WIDTH'(TRIGGER_RST - 1)); // inside the band: stays low
        send_item(ACT_SAMPLE, 12'hFFF);     // capture of three ticks, rate capped
        send_item(ACT_SAMPLE, 12'h000);
        send_item(ACT_SAMPLE, 12'hFFF);     // count not past refractory: no beat
        send_item(ACT_TICK, 12'h123);
        send_item(ACT_SAMPLE, 12'hFFF);     // one-tick interval
        send_item(ACT_PRESS, 12'h000);      // stops running
        send_item(ACT_TICK, 12'hFFF);
        send_item(ACT_PRESS, 12'hFFF);      // restart while the level is high
        send_item(ACT_SAMPLE, 12'h000);

        // Reset-like values with a short debounce; long receiver hold-off midway.
        set_config(int'(TRIGGER_RST), int'(RELEASE_RST), int'(REFRACTORY_RST), 5,
                   int'(TPM_RST), int'(RATE_CAP_RST));
        play_rhythm(120, 1, 40, 15);
        stall_req++;
        play_rhythm(180, 1, 40, 15);

        // Extremes: top trigger, bottom release, smallest dividend, zero cap,
        // presses never past debounce.
        set_config(4095, 0, 0, 65535, 1, 0);
        play_rhythm(150, 1, 20, 15);

        // Extremes the other way: trigger at zero, release at the top, widest
        // refractory window, largest dividend and cap.
        set_config(0, 4095, 255, 0, 131071, 1023);
        play_rhythm(500, 256, 300, 2);

        // Random settings; one phase runs with no idling on either side.
        for (int phase = 0; phase < 4; phase++) begin
            trig = $urandom_range(4095);
            rel  = ($urandom_range(3) != 0) ? $urandom_range(trig) : $urandom_range(4095);
            refr = $urandom_range(20);
            set_config(trig, rel, refr, $urandom_range(30),
                       $urandom_range(1) ? $urandom_range(3000, 1)
                                         : $urandom_range(131071, 1),
                       $urandom_range(1023));
            gaps_on = (phase != 2);
            play_rhythm(170, refr + 1, refr + 40, 15);
        end
        gaps_on = 1'b1;

        drain_results();
        repeat (DRAIN_TAIL) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
